FILE: rtl/assert_macros.svh
// Assertion macros for the directory listing parser.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define DLEP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define DLEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DLEP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define DLEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/dlep_pkg.sv
// Shared types, codes and constants of the directory listing parser.
// No dependencies; used by every module of the block.
package dlep_pkg;

    // Buffer and table sizing
    localparam int OFFSET_BITS = 20;
    localparam int MAX_ENTRIES = 4096;
    localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
    localparam int QUEUE_DEPTH = 4;

    // Result field widths
    localparam int EIDX_BITS = 13;
    localparam int POS_BITS  = 20;
    localparam int LEN_BITS  = 20;
    localparam int BLEN_BITS = 21;

    // Input word kinds
    localparam logic IN_DATA = 1'b0;
    localparam logic IN_END  = 1'b1;

    // Record types
    localparam logic [1:0] REC_ENTRY    = 2'd0;
    localparam logic [1:0] REC_UPDATE   = 2'd1;
    localparam logic [1:0] REC_OVERFLOW = 2'd2;
    localparam logic [1:0] REC_END      = 2'd3;

    // Entry kinds; also select the prefix text
    localparam logic [1:0] KIND_DIR      = 2'd0;
    localparam logic [1:0] KIND_FILE     = 2'd1;
    localparam logic [1:0] KIND_PLAYLIST = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    // Characters
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    // Prefix texts, first character in the top byte
    localparam logic [3:0]  PFX_MAX_LEN   = 4'd10;
    localparam logic [79:0] PFX_TEXT_DIR  = "directory:";
    localparam logic [79:0] PFX_TEXT_FILE = {"file:", 40'h0};
    localparam logic [79:0] PFX_TEXT_PL   = {"playlist:", 8'h0};

    // Record slots of one bundle, in delivery order
    localparam int SLOT_PRIMARY = 0;
    localparam int SLOT_UPD_OLD = 1;
    localparam int SLOT_UPD_END = 2;
    localparam int SLOT_END     = 3;

    // Work handed from the scanner to the record builder
    typedef struct packed {
        logic [3:0]             rec_mask;
        logic                   ovf;
        logic [1:0]             ekind;
        logic [CNT_BITS-1:0]    eidx;
        logic [OFFSET_BITS-1:0] value_start;
        logic [OFFSET_BITS-1:0] value_last;
        logic                   name_cut;
        logic [OFFSET_BITS-1:0] slash_pos;
        logic [OFFSET_BITS-1:0] line_start;
        logic [IDX_BITS-1:0]    p1_idx;
        logic [OFFSET_BITS-1:0] p1_start;
        logic [IDX_BITS-1:0]    p2_idx;
        logic [OFFSET_BITS-1:0] p2_start;
        logic [OFFSET_BITS:0]   end_off;
        logic [CNT_BITS-1:0]    end_count;
    } bundle_t;

    // One result word
    typedef struct packed {
        logic [1:0]           record_type;
        logic [1:0]           entry_kind;
        logic [EIDX_BITS-1:0] entry_index;
        logic [POS_BITS-1:0]  uri_offset;
        logic [LEN_BITS-1:0]  uri_length;
        logic [POS_BITS-1:0]  name_offset;
        logic [LEN_BITS-1:0]  name_length;
        logic [POS_BITS-1:0]  block_start;
        logic [BLEN_BITS-1:0] block_length;
        logic                 last;
    } record_t;

    function automatic logic [3:0] prefix_len(input logic [1:0] which);
        logic [3:0] len;
        unique case (which)
            KIND_DIR:  len = 4'd10;
            KIND_FILE: len = 4'd5;
            default:   len = 4'd9;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [1:0] which,
                                               input logic [3:0] idx);
        logic [79:0] text;
        logic [3:0]  k;
        unique case (which)
            KIND_DIR:  text = PFX_TEXT_DIR;
            KIND_FILE: text = PFX_TEXT_FILE;
            default:   text = PFX_TEXT_PL;
        endcase
        k = (idx < PFX_MAX_LEN) ? (PFX_MAX_LEN - 4'd1 - idx) : 4'd0;
        return text[{k, 3'b000} +: 8];
    endfunction

endpackage

FILE: rtl/dlep_front.sv
// Byte scanner: tracks line, prefix, value and pending file state and
// emits one bundle for each word that causes records. Uses dlep_pkg.
module dlep_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_kind,
    input  logic [7:0]        in_byte,
    output logic              bundle_push,
    output dlep_pkg::bundle_t bundle_data
);

    localparam int OB = dlep_pkg::OFFSET_BITS;
    localparam int CB = dlep_pkg::CNT_BITS;
    localparam int IB = dlep_pkg::IDX_BITS;

    logic [OB:0]   byte_offset_reg, byte_offset_next;
    logic [OB-1:0] line_start_reg, line_start_next;
    logic [3:0]    line_pos_reg, line_pos_next;
    logic [2:0]    match_reg, match_next;
    logic [1:0]    line_kind_reg, line_kind_next;
    logic [OB-1:0] value_start_reg, value_start_next;
    logic          value_started_reg, value_started_next;
    logic [OB-1:0] value_last_reg, value_last_next;
    logic          value_nonempty_reg, value_nonempty_next;
    logic [OB-1:0] slash_pos_reg, slash_pos_next;
    logic          slash_seen_reg, slash_seen_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [IB-1:0] pend_index_reg, pend_index_next;
    logic [OB-1:0] pend_start_reg, pend_start_next;
    logic [CB-1:0] entry_count_reg, entry_count_next;
    logic          overflow_reg, overflow_next;

    logic          is_end;
    logic          is_nl;
    logic [OB-1:0] pos;
    logic [OB:0]   offset_inc;
    logic [OB-1:0] pos_after;
    logic          entry_ok;
    logic          at_max;
    logic          do_finish;
    logic          fin_entry;
    logic          fin_ovf;
    logic          pa_valid;
    logic [IB-1:0] pa_index;
    logic [OB-1:0] pa_start;
    logic [CB-1:0] count_after;
    logic          is_blank;
    logic          start_now;
    logic          started;

    // Classify the word and work out what closing the line does
    always_comb
    begin
        is_end     = (in_kind == dlep_pkg::IN_END);
        is_nl      = (in_byte == dlep_pkg::CH_NL);
        pos        = byte_offset_reg[OB] ? {OB{1'b1}} : byte_offset_reg[OB-1:0];
        offset_inc = byte_offset_reg[OB] ? byte_offset_reg
                                         : byte_offset_reg + (OB+1)'(1);
        pos_after  = offset_inc[OB] ? {OB{1'b1}} : offset_inc[OB-1:0];
        entry_ok   = (line_kind_reg != dlep_pkg::KIND_NONE) && value_nonempty_reg;
        at_max     = (entry_count_reg >= CB'(dlep_pkg::MAX_ENTRIES));
        do_finish  = !overflow_reg && (is_end || is_nl);
        fin_entry  = do_finish && entry_ok && !at_max;
        fin_ovf    = do_finish && entry_ok && at_max;

        // Pending file after the line is closed
        pa_valid = pend_valid_reg;
        pa_index = pend_index_reg;
        pa_start = pend_start_reg;
        if (fin_entry)
        begin
            pa_valid = (line_kind_reg == dlep_pkg::KIND_FILE);
            pa_index = entry_count_reg[IB-1:0];
            pa_start = line_start_reg;
        end
        else if (fin_ovf)
        begin
            pa_valid = 1'b0;
        end
        count_after = fin_entry ? entry_count_reg + CB'(1) : entry_count_reg;

        is_blank  = (in_byte == dlep_pkg::CH_SP) || (in_byte == dlep_pkg::CH_TAB);
        start_now = !value_started_reg && !is_blank;
        started   = value_started_reg || start_now;
    end

    // Build the bundle handed to the record builder
    always_comb
    begin
        bundle_data = '0;
        bundle_data.rec_mask[dlep_pkg::SLOT_PRIMARY] = fin_entry || fin_ovf;
        bundle_data.rec_mask[dlep_pkg::SLOT_UPD_OLD] = fin_entry && pend_valid_reg;
        bundle_data.rec_mask[dlep_pkg::SLOT_UPD_END] = is_end && !overflow_reg
                                                       && !fin_ovf && pa_valid;
        bundle_data.rec_mask[dlep_pkg::SLOT_END]     = is_end;
        bundle_data.ovf         = fin_ovf;
        bundle_data.ekind       = line_kind_reg;
        bundle_data.eidx        = entry_count_reg;
        bundle_data.value_start = value_start_reg;
        bundle_data.value_last  = value_last_reg;
        bundle_data.name_cut    = (line_kind_reg != dlep_pkg::KIND_PLAYLIST)
                                  && slash_seen_reg && (slash_pos_reg < value_last_reg);
        bundle_data.slash_pos   = slash_pos_reg;
        bundle_data.line_start  = line_start_reg;
        bundle_data.p1_idx      = pend_index_reg;
        bundle_data.p1_start    = pend_start_reg;
        bundle_data.p2_idx      = pa_index;
        bundle_data.p2_start    = pa_start;
        bundle_data.end_off     = byte_offset_reg;
        bundle_data.end_count   = count_after;
        bundle_push = in_valid && (bundle_data.rec_mask != 4'd0);
    end

    // Advance the parser state on each accepted word
    always_comb
    begin
        byte_offset_next    = byte_offset_reg;
        line_start_next     = line_start_reg;
        line_pos_next       = line_pos_reg;
        match_next          = match_reg;
        line_kind_next      = line_kind_reg;
        value_start_next    = value_start_reg;
        value_started_next  = value_started_reg;
        value_last_next     = value_last_reg;
        value_nonempty_next = value_nonempty_reg;
        slash_pos_next      = slash_pos_reg;
        slash_seen_next     = slash_seen_reg;
        pend_valid_next     = pend_valid_reg;
        pend_index_next     = pend_index_reg;
        pend_start_next     = pend_start_reg;
        entry_count_next    = entry_count_reg;
        overflow_next       = overflow_reg;

        if (in_valid && is_end)
        begin
            // Drop everything, ready for the next buffer
            byte_offset_next    = '0;
            line_start_next     = '0;
            line_pos_next       = '0;
            match_next          = 3'b111;
            line_kind_next      = dlep_pkg::KIND_NONE;
            value_start_next    = '0;
            value_started_next  = 1'b0;
            value_last_next     = '0;
            value_nonempty_next = 1'b0;
            slash_pos_next      = '0;
            slash_seen_next     = 1'b0;
            pend_valid_next     = 1'b0;
            pend_index_next     = '0;
            pend_start_next     = '0;
            entry_count_next    = '0;
            overflow_next       = 1'b0;
        end
        else if (in_valid && !overflow_reg)
        begin
            byte_offset_next = offset_inc;
            if (is_nl)
            begin
                pend_valid_next     = pa_valid;
                pend_index_next     = pa_index;
                pend_start_next     = pa_start;
                entry_count_next    = count_after;
                overflow_next       = fin_ovf;
                line_start_next     = pos_after;
                line_pos_next       = '0;
                match_next          = 3'b111;
                line_kind_next      = dlep_pkg::KIND_NONE;
                value_start_next    = '0;
                value_started_next  = 1'b0;
                value_last_next     = '0;
                value_nonempty_next = 1'b0;
                slash_pos_next      = '0;
                slash_seen_next     = 1'b0;
            end
            else if (line_kind_reg == dlep_pkg::KIND_NONE)
            begin
                // Match the three prefixes side by side
                if ((line_pos_reg < dlep_pkg::PFX_MAX_LEN) && (match_reg != 3'b000))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (match_reg[i])
                        begin
                            if ((line_pos_reg < dlep_pkg::prefix_len(2'(i)))
                                && (in_byte == dlep_pkg::prefix_char(2'(i), line_pos_reg)))
                            begin
                                if ((line_pos_reg + 4'd1) == dlep_pkg::prefix_len(2'(i)))
                                begin
                                    line_kind_next = 2'(i);
                                end
                            end
                            else
                            begin
                                match_next[i] = 1'b0;
                            end
                        end
                    end
                    line_pos_next = line_pos_reg + 4'd1;
                end
            end
            else
            begin
                // Track the trimmed value and its last slash
                if (start_now)
                begin
                    value_started_next = 1'b1;
                    value_start_next   = pos;
                end
                if (started && !is_blank && (in_byte != dlep_pkg::CH_CR))
                begin
                    value_nonempty_next = 1'b1;
                    value_last_next     = pos;
                    if (in_byte == dlep_pkg::CH_SLASH)
                    begin
                        slash_seen_next = 1'b1;
                        slash_pos_next  = pos;
                    end
                end
            end
        end
    end

    // Hold the parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg    <= '0;
            line_start_reg     <= '0;
            line_pos_reg       <= '0;
            match_reg          <= 3'b111;
            line_kind_reg      <= dlep_pkg::KIND_NONE;
            value_start_reg    <= '0;
            value_started_reg  <= 1'b0;
            value_last_reg     <= '0;
            value_nonempty_reg <= 1'b0;
            slash_pos_reg      <= '0;
            slash_seen_reg     <= 1'b0;
            pend_valid_reg     <= 1'b0;
            pend_index_reg     <= '0;
            pend_start_reg     <= '0;
            entry_count_reg    <= '0;
            overflow_reg       <= 1'b0;
        end
        else
        begin
            byte_offset_reg    <= byte_offset_next;
            line_start_reg     <= line_start_next;
            line_pos_reg       <= line_pos_next;
            match_reg          <= match_next;
            line_kind_reg      <= line_kind_next;
            value_start_reg    <= value_start_next;
            value_started_reg  <= value_started_next;
            value_last_reg     <= value_last_next;
            value_nonempty_reg <= value_nonempty_next;
            slash_pos_reg      <= slash_pos_next;
            slash_seen_reg     <= slash_seen_next;
            pend_valid_reg     <= pend_valid_next;
            pend_index_reg     <= pend_index_next;
            pend_start_reg     <= pend_start_next;
            entry_count_reg    <= entry_count_next;
            overflow_reg       <= overflow_next;
        end
    end

endmodule

FILE: rtl/dlep_queue.sv
// Short bundle queue between the scanner and the record builder.
// Uses dlep_pkg for the bundle type and depth.
module dlep_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  dlep_pkg::bundle_t wr_data,
    input  logic              rd_en,
    output dlep_pkg::bundle_t rd_data,
    output logic              full,
    output logic              empty
);

    localparam int DEPTH = dlep_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    dlep_pkg::bundle_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr;
    logic          do_rd;

    // Advance pointers and fill count
    always_comb
    begin
        do_wr       = wr_en && !full;
        do_rd       = rd_en && !empty;
        wr_ptr_next = do_wr ? ((wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1))
                            : wr_ptr_reg;
        rd_ptr_next = do_rd ? ((rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1))
                            : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming bundle
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/dlep_back.sv
// Record builder: expands the head bundle into result words, one a cycle
// while the output is taken, into an output register. Uses dlep_pkg.
module dlep_back (
    input  logic              clk,
    input  logic              rst_n,
    input  dlep_pkg::bundle_t head,
    input  logic              head_empty,
    output logic              head_pop,
    input  logic              out_take,
    output logic              out_valid,
    output dlep_pkg::record_t out_rec
);

    localparam int OB = dlep_pkg::OFFSET_BITS;
    localparam int EW = dlep_pkg::EIDX_BITS;
    localparam int PW = dlep_pkg::POS_BITS;
    localparam int LW = dlep_pkg::LEN_BITS;
    localparam int BW = dlep_pkg::BLEN_BITS;

    logic [3:0]        done_reg, done_next;
    logic              out_valid_reg, out_valid_next;
    dlep_pkg::record_t out_rec_reg;
    dlep_pkg::record_t rec;
    logic [3:0]        remain;
    logic [3:0]        sel;
    logic              last_word;
    logic              load;
    logic [OB:0]       uri_len_w;
    logic [OB-1:0]     name_off_w;
    logic [OB-1:0]     name_len_w;
    logic [OB-1:0]     old_len_w;
    logic [OB:0]       end_len_w;

    // Pick the next record of the head bundle
    always_comb
    begin
        remain    = head.rec_mask & ~done_reg;
        sel       = remain & (~remain + 4'd1);
        last_word = ((remain & ~sel) == 4'd0);
        load      = !head_empty && (!out_valid_reg || out_take);
        head_pop  = load && last_word;
    end

    // Work out lengths and form the record
    always_comb
    begin
        uri_len_w  = {1'b0, head.value_last} + (OB+1)'(1) - {1'b0, head.value_start};
        name_off_w = head.slash_pos + OB'(1);
        name_len_w = head.value_last - head.slash_pos;
        old_len_w  = head.line_start - head.p1_start;
        end_len_w  = head.end_off - {1'b0, head.p2_start};

        rec      = '0;
        rec.last = last_word;
        if (sel[dlep_pkg::SLOT_PRIMARY])
        begin
            rec.entry_index = EW'(head.eidx);
            if (head.ovf)
            begin
                rec.record_type = dlep_pkg::REC_OVERFLOW;
            end
            else
            begin
                rec.record_type = dlep_pkg::REC_ENTRY;
                rec.entry_kind  = head.ekind;
                rec.uri_offset  = PW'(head.value_start);
                rec.uri_length  = LW'(uri_len_w);
                rec.name_offset = head.name_cut ? PW'(name_off_w) : PW'(head.value_start);
                rec.name_length = head.name_cut ? LW'(name_len_w) : LW'(uri_len_w);
                rec.block_start = PW'(head.line_start);
            end
        end
        else if (sel[dlep_pkg::SLOT_UPD_OLD])
        begin
            rec.record_type  = dlep_pkg::REC_UPDATE;
            rec.entry_kind   = dlep_pkg::KIND_FILE;
            rec.entry_index  = EW'(head.p1_idx);
            rec.block_start  = PW'(head.p1_start);
            rec.block_length = BW'(old_len_w);
        end
        else if (sel[dlep_pkg::SLOT_UPD_END])
        begin
            rec.record_type  = dlep_pkg::REC_UPDATE;
            rec.entry_kind   = dlep_pkg::KIND_FILE;
            rec.entry_index  = EW'(head.p2_idx);
            rec.block_start  = PW'(head.p2_start);
            rec.block_length = BW'(end_len_w);
        end
        else
        begin
            rec.record_type = dlep_pkg::REC_END;
            rec.entry_index = EW'(head.end_count);
        end
    end

    // Mark records done and hold the output word until taken
    always_comb
    begin
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            done_next      = last_word ? 4'd0 : (done_reg | sel);
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_rec_reg <= rec;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;

endmodule

FILE: rtl/dir_listing_entry_parser_top.sv
// Top level of the directory listing parser: scanner, bundle queue and
// record builder. Uses dlep_pkg and assert_macros.svh.
//
//   channel   handshake            payload
//   input     push / full          kind, data_byte
//   result    empty / pop          record_type .. block_length, last
//
// One input word is taken every cycle while full is low.
// A word that closes an entry line or ends the buffer yields one to four
// result words; the record builder drains them one per cycle while the
// result port takes them, through the queue and then its output register. A
// queue of four bundles absorbs bursts; full rises while it holds four.
// Reset is asynchronous and clears all parser state at once. A stalled
// result port holds its word and, once the queue fills, stalls the input.
`include "assert_macros.svh"

module dir_listing_entry_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  record_type,
    output logic [1:0]  entry_kind,
    output logic [12:0] entry_index,
    output logic [19:0] uri_offset,
    output logic [19:0] uri_length,
    output logic [19:0] name_offset,
    output logic [19:0] name_length,
    output logic [19:0] block_start,
    output logic [20:0] block_length,
    output logic        last
);

    logic              in_valid;
    logic              q_push;
    dlep_pkg::bundle_t q_wr;
    dlep_pkg::bundle_t q_head;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              out_valid;
    logic              out_take;
    dlep_pkg::record_t out_rec;

    assign full     = q_full;
    assign in_valid = push && !q_full;
    assign empty    = !out_valid;
    assign out_take = pop && out_valid;

    dlep_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_kind     (kind),
        .in_byte     (data_byte),
        .bundle_push (q_push),
        .bundle_data (q_wr)
    );

    dlep_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    dlep_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_empty (q_empty),
        .head_pop   (q_pop),
        .out_take   (out_take),
        .out_valid  (out_valid),
        .out_rec    (out_rec)
    );

    // Spread the result word over the ports
    assign record_type  = out_rec.record_type;
    assign entry_kind   = out_rec.entry_kind;
    assign entry_index  = out_rec.entry_index;
    assign uri_offset   = out_rec.uri_offset;
    assign uri_length   = out_rec.uri_length;
    assign name_offset  = out_rec.name_offset;
    assign name_length  = out_rec.name_length;
    assign block_start  = out_rec.block_start;
    assign block_length = out_rec.block_length;
    assign last         = out_rec.last;

    // Checks
    `DLEP_ASSERT_IMPLY(a_no_push_when_full, clk, rst_n, q_push, !q_full, "bundle pushed into full queue")
    `DLEP_ASSERT_IMPLY(a_head_has_work, clk, rst_n, !q_empty, q_head.rec_mask != 4'd0, "queued bundle without records")
    `DLEP_ASSERT_IMPLY(a_end_is_last, clk, rst_n, out_valid && (out_rec.record_type == dlep_pkg::REC_END), out_rec.last, "end record not marked last")
    `DLEP_ASSERT_NEXT(a_end_word_clears, clk, rst_n, in_valid && (kind == dlep_pkg::IN_END), !q_empty, "end word left no bundle")

endmodule

FILE: tb/dir_listing_entry_parser_top_tb.sv
// Testbench for dir_listing_entry_parser_top: feeds listing bytes and end markers,
// predicts every record with an untimed parser model and checks each popped word.
// Depends on dlep_pkg and the RTL of dir_listing_entry_parser_top.
module dir_listing_entry_parser_top_tb;
    import dlep_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_WORDS    = 40;
    localparam logic [OFFSET_BITS:0] OFF_LIMIT = {1'b1, {OFFSET_BITS{1'b0}}};

    // Untimed parser model plus the queue of records it still owes
    class listing_scoreboard;
        record_t                due_records[$];
        int                     errors;
        string                  pfx_text[3];
        logic [OFFSET_BITS:0]   byte_off;
        logic [OFFSET_BITS-1:0] line_start;
        logic [OFFSET_BITS-1:0] value_start;
        logic [OFFSET_BITS-1:0] value_last;
        logic [OFFSET_BITS-1:0] slash_pos;
        logic [OFFSET_BITS-1:0] pend_start;
        logic [3:0]             line_pos;
        logic [2:0]             pfx_live;
        logic [1:0]             line_kind;
        bit                     value_started;
        bit                     value_nonempty;
        bit                     slash_seen;
        bit                     pend_valid;
        bit                     table_full;
        logic [IDX_BITS-1:0]    pend_idx;
        logic [CNT_BITS-1:0]    n_entries;

        function new();
            pfx_text[KIND_DIR]      = "directory:";
            pfx_text[KIND_FILE]     = "file:";
            pfx_text[KIND_PLAYLIST] = "playlist:";
            errors = 0;
            start_buffer();
        endfunction

        function void clear_line(input logic [OFFSET_BITS-1:0] start);
            line_start     = start;
            line_pos       = '0;
            pfx_live       = 3'b111;
            line_kind      = KIND_NONE;
            value_start    = '0;
            value_started  = 1'b0;
            value_last     = '0;
            value_nonempty = 1'b0;
            slash_pos      = '0;
            slash_seen     = 1'b0;
        endfunction

        function void start_buffer();
            byte_off   = '0;
            clear_line('0);
            pend_valid = 1'b0;
            pend_idx   = '0;
            pend_start = '0;
            n_entries  = '0;
            table_full = 1'b0;
        endfunction

        function void add_record(input logic [1:0] rtype, input logic [1:0] ekind,
                                 input logic [CNT_BITS-1:0] idx,
                                 input logic [OFFSET_BITS-1:0] uo, ul, no, nl, bs,
                                 input logic [OFFSET_BITS:0] bl);
            record_t r;
            r.record_type  = rtype;
            r.entry_kind   = ekind;
            r.entry_index  = idx;
            r.uri_offset   = uo;
            r.uri_length   = ul;
            r.name_offset  = no;
            r.name_length  = nl;
            r.block_start  = bs;
            r.block_length = bl;
            r.last         = 1'b0;
            due_records.push_back(r);
        endfunction

        // Close a line: an entry and the update of the file before it, or overflow
        function void close_line();
            logic [OFFSET_BITS-1:0] uri_len;
            logic [OFFSET_BITS-1:0] name_off;
            logic [OFFSET_BITS-1:0] name_len;
            if (line_kind == KIND_NONE || !value_nonempty)
                return;
            if (n_entries >= MAX_ENTRIES)
            begin
                add_record(REC_OVERFLOW, '0, n_entries, '0, '0, '0, '0, '0, '0);
                table_full = 1'b1;
                pend_valid = 1'b0;
                return;
            end
            uri_len  = value_last - value_start + 1'b1;
            name_off = value_start;
            name_len = uri_len;
            if (line_kind != KIND_PLAYLIST && slash_seen && slash_pos < value_last)
            begin
                name_off = slash_pos + 1'b1;
                name_len = value_last - slash_pos;
            end
            add_record(REC_ENTRY, line_kind, n_entries, value_start, uri_len,
                       name_off, name_len, line_start, '0);
            if (pend_valid)
                add_record(REC_UPDATE, KIND_FILE, pend_idx, '0, '0, '0, '0, pend_start,
                           {1'b0, line_start} - {1'b0, pend_start});
            pend_valid = (line_kind == KIND_FILE);
            if (line_kind == KIND_FILE)
            begin
                pend_idx   = n_entries[IDX_BITS-1:0];
                pend_start = line_start;
            end
            n_entries++;
        endfunction

        // Advance the model by one accepted input word
        function void note_word(input logic k, input logic [7:0] c);
            int                     first;
            logic [OFFSET_BITS-1:0] at;
            record_t                tail;
            first = due_records.size();
            if (k == IN_END)
            begin
                if (!table_full)
                begin
                    close_line();
                    if (!table_full && pend_valid)
                        add_record(REC_UPDATE, KIND_FILE, pend_idx, '0, '0, '0, '0,
                                   pend_start, byte_off - {1'b0, pend_start});
                end
                add_record(REC_END, '0, n_entries, '0, '0, '0, '0, '0, '0);
                start_buffer();
            end
            else if (!table_full)
            begin
                at = (byte_off < OFF_LIMIT) ? byte_off[OFFSET_BITS-1:0] : '1;
                if (byte_off < OFF_LIMIT)
                    byte_off++;
                if (c == CH_NL)
                begin
                    close_line();
                    clear_line((byte_off < OFF_LIMIT) ? byte_off[OFFSET_BITS-1:0] : '1);
                end
                else if (line_kind == KIND_NONE)
                begin
                    // match all three prefixes side by side
                    if (line_pos < PFX_MAX_LEN && pfx_live != 3'b000)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            if (!pfx_live[i])
                                continue;
                            if (line_pos < pfx_text[i].len() && c == pfx_text[i][line_pos])
                            begin
                                if (line_pos + 1 == pfx_text[i].len())
                                    line_kind = 2'(i);
                            end
                            else
                                pfx_live[i] = 1'b0;
                        end
                        line_pos++;
                    end
                end
                else
                begin
                    // trim leading blanks; CR starts the value but is never kept
                    if (!value_started && c != CH_SP && c != CH_TAB)
                    begin
                        value_started = 1'b1;
                        value_start   = at;
                    end
                    if (value_started && c != CH_SP && c != CH_TAB && c != CH_CR)
                    begin
                        value_nonempty = 1'b1;
                        value_last     = at;
                        if (c == CH_SLASH)
                        begin
                            slash_seen = 1'b1;
                            slash_pos  = at;
                        end
                    end
                end
            end
            if (due_records.size() > first)
            begin
                tail = due_records.pop_back();
                tail.last = 1'b1;
                due_records.push_back(tail);
            end
        endfunction

        function void match_field(input string what, input longint unsigned want,
                                  input longint unsigned got);
            if (want != got)
            begin
                $display("%0t ERROR: %s expected %0d actual %0d", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_record(input record_t got);
            record_t want;
            if (due_records.size() == 0)
            begin
                $display("%0t ERROR: unexpected record, expected none actual type %0d index %0d",
                         $time, got.record_type, got.entry_index);
                errors++;
                return;
            end
            want = due_records.pop_front();
            match_field("record_type", want.record_type, got.record_type);
            match_field("entry_kind", want.entry_kind, got.entry_kind);
            match_field("entry_index", want.entry_index, got.entry_index);
            match_field("uri_offset", want.uri_offset, got.uri_offset);
            match_field("uri_length", want.uri_length, got.uri_length);
            match_field("name_offset", want.name_offset, got.name_offset);
            match_field("name_length", want.name_length, got.name_length);
            match_field("block_start", want.block_start, got.block_start);
            match_field("block_length", want.block_length, got.block_length);
            match_field("last", want.last, got.last);
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        kind      = IN_DATA;
    logic [7:0]  data_byte = '0;
    logic        pop       = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  record_type;
    logic [1:0]  entry_kind;
    logic [12:0] entry_index;
    logic [19:0] uri_offset;
    logic [19:0] uri_length;
    logic [19:0] name_offset;
    logic [19:0] name_length;
    logic [19:0] block_start;
    logic [20:0] block_length;
    logic        last;

    record_t           result_word;
    listing_scoreboard sb = new();
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                words_sent    = 0;
    int                quiet_cycles  = 0;
    int                hold_left     = 0;
    bit                hold_request  = 1'b0;
    bit                next_pop      = 1'b0;

    dir_listing_entry_parser_top DUT (.*);

    assign result_word = {record_type, entry_kind, entry_index, uri_offset, uri_length,
                          name_offset, name_length, block_start, block_length, last};

    always #5 clk = ~clk;

    // Result side: check at the rising edge, change pop at the falling edge
    always
    begin
        @(posedge clk);
        if (pop && !empty)
            sb.check_record(result_word);
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            next_pop = 1'b0;
        end
        else
            next_pop = ($urandom_range(99) >= recv_idle_pct);
        @(negedge clk);
        pop <= next_pop;
    end

    // Stop a hung run: count cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL dir_listing_entry_parser_top");
            $finish;
        end
    end

    // Offer one word, hold it until taken; enter and leave at a falling edge
    task automatic send_word(input logic k, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        kind      <= k;
        data_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_word(k, b);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(IN_DATA, s[i]);
    endtask

    function automatic logic [7:0] any_but_newline();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_NL);
        return b;
    endfunction

    function automatic logic [7:0] blank_char(input bit allow_cr);
        int sel;
        sel = $urandom_range(allow_cr ? 2 : 1);
        return (sel == 0) ? CH_SP : (sel == 1) ? CH_TAB : CH_CR;
    endfunction

    // One listing line: mostly real prefixes, some broken ones, some junk
    task automatic send_random_line(input bit with_nl);
        int         sel;
        int         n;
        logic [1:0] k;
        sel = $urandom_range(99);
        k   = 2'($urandom_range(2));
        if (sel < 75)
            send_text(sb.pfx_text[k]);
        else if (sel < 87)
        begin
            n = $urandom_range(sb.pfx_text[k].len() - 1);
            send_text(sb.pfx_text[k].substr(0, n - 1));
            send_word(IN_DATA, any_but_newline());
        end
        else
        begin
            n = $urandom_range(12);
            repeat (n)
                send_word(IN_DATA, 8'($urandom_range(255)));
        end
        repeat ($urandom_range(2))
            send_word(IN_DATA, blank_char(1'b0));
        repeat ($urandom_range(8))
        begin
            sel = $urandom_range(99);
            if (sel < 50)
                send_word(IN_DATA, 8'h61 + 8'($urandom_range(25)));
            else if (sel < 65)
                send_word(IN_DATA, CH_SLASH);
            else if (sel < 80)
                send_word(IN_DATA, blank_char(1'b1));
            else
                send_word(IN_DATA, any_but_newline());
        end
        repeat ($urandom_range(2))
            send_word(IN_DATA, blank_char(1'b1));
        if (with_nl)
            send_word(IN_DATA, CH_NL);
    endtask

    // A buffer of a few lines; the last one is sometimes left open
    task automatic send_random_buffer();
        int lines;
        lines = $urandom_range(6);
        for (int i = 0; i < lines; i++)
            send_random_line(i < lines - 1 || $urandom_range(3) != 0);
        send_word(IN_END, 8'($urandom_range(255)));
    endtask

    task automatic run_random(input int count);
        int stop;
        stop = words_sent + count;
        while (words_sent < stop)
            send_random_buffer();
    endtask

    // Hold the input low until every owed record has been popped
    task automatic wait_for_results();
        push <= 1'b0;
        do
            @(negedge clk);
        while (sb.due_records.size() != 0);
    endtask

    // Keep offering short entries while the result side is held off
    task automatic fill_while_held();
        hold_request = 1'b1;
        repeat (12)
        begin
            send_text(sb.pfx_text[$urandom_range(2)]);
            send_word(IN_DATA, 8'h61 + 8'($urandom_range(25)));
            send_word(IN_DATA, CH_SLASH);
            send_word(IN_DATA, 8'h61 + 8'($urandom_range(25)));
            send_word(IN_DATA, CH_NL);
        end
        send_word(IN_END, 8'($urandom_range(255)));
    endtask

    task automatic run_directed();
        // slash in the name, then leading blanks with a trailing slash and CR
        send_text("directory:a/b\n");
        send_text("file: \tx/");
        send_word(IN_DATA, CH_CR);
        send_word(IN_DATA, CH_NL);
        // playlist keeps the whole value; a value of CR and blanks gives nothing
        send_text("playlist:p/q \n");
        send_text("file:");
        send_word(IN_DATA, CH_CR);
        send_text(" \n");
        // byte extremes on a junk line, then an open file line closed by the end
        send_word(IN_DATA, 8'h00);
        send_word(IN_DATA, 8'hff);
        send_text("\nfile:y");
        send_word(IN_END, 8'hff);
        // empty buffer
        send_word(IN_END, 8'h00);
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender rarely idle, receiver often idle
        send_idle_pct = 7;
        recv_idle_pct = 56;
        @(negedge clk);
        run_directed();
        fill_while_held();
        run_random(PHASE_WORDS);

        // sender often idle, receiver rarely idle
        send_idle_pct = 56;
        recv_idle_pct = 7;
        run_random(PHASE_WORDS / 2);
        wait_for_results();
        run_random(PHASE_WORDS / 2);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_WORDS / 2);
        run_random(PHASE_WORDS / 2);

        // drain, then allow the pipeline to settle
        push <= 1'b0;
        while (sb.due_records.size() != 0)
            @(negedge clk);
        repeat (20)
            @(negedge clk);
        if (sb.errors == 0 && sb.due_records.size() == 0)
            $display("PASS dir_listing_entry_parser_top");
        else
            $display("FAIL dir_listing_entry_parser_top");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/dlep_pkg.sv
rtl/dlep_front.sv
rtl/dlep_queue.sv
rtl/dlep_back.sv
rtl/dir_listing_entry_parser_top.sv
tb/dir_listing_entry_parser_top_tb.sv
